/* hw/rtl/postfix_stack_evaluator_unit_macros.svh */
// Assertion macros for the postfix evaluator.
// Included by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_MACROS_SVH

// property checked on every edge out of reset
`define PSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
  `PSE_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* hw/rtl/pse_pkg.sv */
// Shared types, codes and sizes for the postfix evaluator.
// No dependencies; imported by every module of the block.
package pse_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int IO_WIDTH    = 32;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(DATA_WIDTH);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [DEPTH_W-1:0]           depth_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_UNARY  = 2'd1,
    REQ_BINARY = 2'd2
  } req_type_e;

  typedef enum logic [3:0] {
    UOP_PLUS = 4'd0,
    UOP_NEG  = 4'd1,
    UOP_NOT  = 4'd2
  } unary_op_e;

  typedef enum logic [3:0] {
    BOP_OR  = 4'd0,
    BOP_AND = 4'd1,
    BOP_LT  = 4'd2,
    BOP_GT  = 4'd3,
    BOP_LE  = 4'd4,
    BOP_GE  = 4'd5,
    BOP_EQ  = 4'd6,
    BOP_NE  = 4'd7,
    BOP_ADD = 4'd8,
    BOP_SUB = 4'd9,
    BOP_MUL = 4'd10,
    BOP_DIV = 4'd11,
    BOP_MOD = 4'd12
  } binary_op_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_UNDERFLOW = 3'd1,
    ERR_OVERFLOW  = 3'd2,
    ERR_DIVZERO   = 3'd3,
    ERR_BADOP     = 3'd4,
    ERR_DEPTH     = 3'd5
  } err_code_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FINISH
  } state_e;

  // what the held token does to the stack
  typedef enum logic [2:0] {
    TK_SKIP,
    TK_FAULT,
    TK_PUSH,
    TK_UNARY,
    TK_BINARY,
    TK_DIVIDE
  } tok_kind_e;

  typedef struct packed {
    logic load_token;
    logic commit;
    logic div_start;
    logic div_write;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    tok_kind_e kind;
    logic      tok_last;
    logic      div_done;
    logic      out_free;
  } dp_status_t;

endpackage

/* hw/rtl/pse_ctrl.sv */
// Token sequencer for the postfix evaluator.
// Depends on pse_pkg; drives the datapath through ctrl_cmd_t.
module pse_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pse_pkg::dp_status_t status,
  output pse_pkg::ctrl_cmd_t  cmd
);
  import pse_pkg::*;

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_token = 1'b1;
          state_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.kind == TK_DIVIDE) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.commit = 1'b1;
          state_next = status.tok_last ? S_FINISH : S_IDLE;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.div_write = 1'b1;
          state_next    = status.tok_last ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/pse_divider.sv */
// Restoring signed divider, one quotient bit per cycle.
// Depends on pse_pkg; used by pse_datapath for div and mod.
module pse_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pse_pkg::data_t dividend,
  input  pse_pkg::data_t divisor,
  output logic          done,
  output pse_pkg::data_t quotient,
  output pse_pkg::data_t remainder
);
  import pse_pkg::*;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] udiv;
  logic                  neg_q;
  logic                  neg_r;
  logic [DATA_WIDTH:0]   partial;
  logic [DATA_WIDTH:0]   trial;

  assign partial = {rem, quo[DATA_WIDTH-1]};
  assign trial   = partial - {1'b0, udiv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DATA_WIDTH - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= '0;
      rem   <= '0;
      quo   <= dividend[DATA_WIDTH-1] ? -dividend : dividend;
      udiv  <= divisor[DATA_WIDTH-1] ? -divisor : divisor;
      neg_q <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      neg_r <= dividend[DATA_WIDTH-1];
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (!trial[DATA_WIDTH]) begin
        rem <= trial[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= partial[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient  = neg_q ? -quo : quo;
  assign remainder = neg_r ? -rem : rem;

endmodule

/* hw/rtl/pse_datapath.sv */
// Stack, token register, ALU and output register of the postfix evaluator.
// Depends on pse_pkg and pse_divider; commanded by pse_ctrl.
module pse_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  pse_pkg::ctrl_cmd_t    cmd,
  output pse_pkg::dp_status_t   status,
  input  logic [1:0]            req_type,
  input  logic [3:0]            op_code,
  input  logic signed [31:0]    operand_value,
  input  logic                  last_token,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    result_value,
  output logic [2:0]            error_code
);
  import pse_pkg::*;

  // held token
  logic [1:0]                tok_type;
  logic [3:0]                tok_op;
  logic signed [IO_WIDTH-1:0] tok_value;
  logic                      tok_last;

  // top of stack lives in tos; memory holds entries below it
  data_t                     tos;
  depth_t                    depth;
  err_code_e                 err_latch;
  logic [DATA_WIDTH-1:0]     mem [STACK_DEPTH];
  data_t                     rd_data;
  depth_t                    depth_m1;
  depth_t                    depth_m2;

  tok_kind_e                 kind;
  err_code_e                 tok_err;
  data_t                     un_res;
  data_t                     bin_res;
  data_t                     push_val;
  data_t                     div_q;
  data_t                     div_r;
  logic                      div_done;
  logic                      is_divmod;

  assign depth_m1  = depth - 1'b1;
  assign depth_m2  = depth - DEPTH_W'(2);
  assign push_val  = DATA_WIDTH'(tok_value);
  assign is_divmod = (tok_op == BOP_DIV) || (tok_op == BOP_MOD);

  always_comb begin
    kind    = TK_SKIP;
    tok_err = ERR_NONE;
    if (err_latch == ERR_NONE) begin
      unique case (tok_type)
        REQ_PUSH: begin
          if (depth >= DEPTH_W'(STACK_DEPTH)) begin
            kind    = TK_FAULT;
            tok_err = ERR_OVERFLOW;
          end else begin
            kind = TK_PUSH;
          end
        end
        REQ_UNARY: begin
          if (tok_op > UOP_NOT) begin
            kind    = TK_FAULT;
            tok_err = ERR_BADOP;
          end else if (depth == '0) begin
            kind    = TK_FAULT;
            tok_err = ERR_UNDERFLOW;
          end else begin
            kind = TK_UNARY;
          end
        end
        REQ_BINARY: begin
          if (tok_op > BOP_MOD) begin
            kind    = TK_FAULT;
            tok_err = ERR_BADOP;
          end else if (depth < DEPTH_W'(2)) begin
            kind    = TK_FAULT;
            tok_err = ERR_UNDERFLOW;
          end else if (is_divmod && tos == '0) begin
            // pops both and pushes zero
            kind    = TK_BINARY;
            tok_err = ERR_DIVZERO;
          end else if (is_divmod) begin
            kind = TK_DIVIDE;
          end else begin
            kind = TK_BINARY;
          end
        end
        default: begin
          kind    = TK_FAULT;
          tok_err = ERR_BADOP;
        end
      endcase
    end
  end

  always_comb begin
    unique case (tok_op)
      UOP_NEG: un_res = -tos;
      UOP_NOT: un_res = DATA_WIDTH'(tos == '0);
      default: un_res = tos;
    endcase
  end

  // left operand from memory, right operand in tos
  always_comb begin
    unique case (tok_op)
      BOP_OR:  bin_res = DATA_WIDTH'(rd_data != '0 || tos != '0);
      BOP_AND: bin_res = DATA_WIDTH'(rd_data != '0 && tos != '0);
      BOP_LT:  bin_res = DATA_WIDTH'(rd_data < tos);
      BOP_GT:  bin_res = DATA_WIDTH'(rd_data > tos);
      BOP_LE:  bin_res = DATA_WIDTH'(rd_data <= tos);
      BOP_GE:  bin_res = DATA_WIDTH'(rd_data >= tos);
      BOP_EQ:  bin_res = DATA_WIDTH'(rd_data == tos);
      BOP_NE:  bin_res = DATA_WIDTH'(rd_data != tos);
      BOP_ADD: bin_res = rd_data + tos;
      BOP_SUB: bin_res = rd_data - tos;
      BOP_MUL: bin_res = rd_data * tos;
      default: bin_res = '0;
    endcase
  end

  pse_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (rd_data),
    .divisor   (tos),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // stack memory: one write, one registered read at depth - 2
  always_ff @(posedge clk) begin
    if (cmd.commit && kind == TK_PUSH && depth != '0) begin
      mem[depth_m1[ADDR_W-1:0]] <= tos;
    end
    rd_data <= mem[depth_m2[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      err_latch <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        if (tok_err != ERR_NONE) begin
          err_latch <= tok_err;
        end
        if (kind == TK_PUSH) begin
          depth <= depth + 1'b1;
        end else if (kind == TK_BINARY) begin
          depth <= depth_m1;
        end
      end
      if (cmd.div_write) begin
        depth <= depth_m1;
      end
      if (cmd.emit) begin
        depth     <= '0;
        err_latch <= ERR_NONE;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_token) begin
      tok_type  <= req_type;
      tok_op    <= op_code;
      tok_value <= operand_value;
      tok_last  <= last_token;
    end
    if (cmd.commit) begin
      if (kind == TK_PUSH) begin
        tos <= push_val;
      end else if (kind == TK_UNARY) begin
        tos <= un_res;
      end else if (kind == TK_BINARY) begin
        tos <= bin_res;
      end
    end
    if (cmd.div_write) begin
      tos <= (tok_op == BOP_MOD) ? div_r : div_q;
    end
    if (cmd.emit) begin
      if (err_latch != ERR_NONE) begin
        error_code   <= err_latch;
        result_value <= '0;
      end else if (depth != DEPTH_W'(1)) begin
        error_code   <= ERR_DEPTH;
        result_value <= '0;
      end else begin
        error_code   <= ERR_NONE;
        result_value <= IO_WIDTH'(tos);
      end
    end
  end

  assign status.kind     = kind;
  assign status.tok_last = tok_last;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || !out_stall;

endmodule

/* hw/rtl/postfix_stack_evaluator_unit.sv */
// Postfix expression evaluator: takes one token word at a time (push a value, or a
// unary or binary operator) and returns one word with the value and an error code
// when the word marked last has been processed. Pushes, unary operators and all
// binary operators but div and mod are accepted and then executed; div and mod with a
// nonzero divisor go through the divider, which retires one quotient bit per cycle.
// After the last token of an expression the output register is loaded, and the
// evaluator waits for it while the output is stalled; a new token can be accepted
// while a result word is still waiting. The top of stack is kept in a register and
// the rest of the stack in a memory with one write and one read port that needs no
// clearing after reset.
module postfix_stack_evaluator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [3:0]         op_code,
  input  logic signed [31:0] operand_value,
  input  logic               last_token,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_value,
  output logic [2:0]         error_code
);
  import pse_pkg::*;

  `include "postfix_stack_evaluator_unit_macros.svh"

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pse_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .req_type      (req_type),
    .op_code       (op_code),
    .operand_value (operand_value),
    .last_token    (last_token),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_value  (result_value),
    .error_code    (error_code)
  );

  `PSE_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
  `PSE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")
  `PSE_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid, "emitted result not presented")
  `PSE_ASSERT(a_err_zero, out_valid && error_code != ERR_NONE |-> result_value == '0, "value with error")

endmodule
